[rtl/rme_pkg.sv]
// ----------------------------------------------------------------------------
// rme_pkg: shared constants and helpers for rotation_matrix_to_euler
// fixed-point arctangent table, field widths and the angle rounding function
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned ElemW      = 16;
  localparam int unsigned AngW       = 16;
  localparam int unsigned LimitW     = 15;
  localparam int unsigned SqW        = 32;
  localparam int unsigned SyW        = 17;
  localparam int unsigned TabLen     = 24;
  localparam int unsigned CordicStepsDef = 16;
  // datapath: operand (17 bits signed) scaled by 2^16, plus CORDIC growth
  localparam int unsigned CdW        = 36;
  localparam int unsigned AccW       = 33;

  localparam logic signed [AccW-1:0] PiHalf = 33'sd843314857;

  function automatic logic signed [AccW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AccW-1:0] r;
    case (i)
      5'd0:  r = 33'sd421657428;
      5'd1:  r = 33'sd248918915;
      5'd2:  r = 33'sd131521918;
      5'd3:  r = 33'sd66762579;
      5'd4:  r = 33'sd33510843;
      5'd5:  r = 33'sd16771758;
      5'd6:  r = 33'sd8387925;
      5'd7:  r = 33'sd4194219;
      5'd8:  r = 33'sd2097141;
      5'd9:  r = 33'sd1048575;
      5'd10: r = 33'sd524288;
      5'd11: r = 33'sd262144;
      5'd12: r = 33'sd131072;
      5'd13: r = 33'sd65536;
      5'd14: r = 33'sd32768;
      5'd15: r = 33'sd16384;
      5'd16: r = 33'sd8192;
      5'd17: r = 33'sd4096;
      5'd18: r = 33'sd2048;
      5'd19: r = 33'sd1024;
      5'd20: r = 33'sd512;
      5'd21: r = 33'sd256;
      5'd22: r = 33'sd128;
      5'd23: r = 33'sd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round Q3.29 to Q3.13 and saturate
  function automatic logic [AngW-1:0] acc_to_angle(input logic signed [AccW-1:0] acc);
    logic signed [AccW:0] s;
    logic signed [AccW-16:0] r;
    s = {acc[AccW-1], acc} + (AccW+1)'(32768);
    r = s[AccW:16];
    if (r > 18'sd32767) return 16'h7fff;
    if (r < -18'sd32768) return 16'h8000;
    return r[AngW-1:0];
  endfunction

  typedef struct packed {
    logic signed [CdW-1:0]  x;
    logic signed [CdW-1:0]  y;
    logic signed [AccW-1:0] acc;
    logic                   zero;
  } cd_t;

endpackage

[rtl/rme_cordic.sv]
// ----------------------------------------------------------------------------
// rme_cordic: pipelined vectoring CORDIC atan2
// one rotation per register stage, plus a pre-rotation and an output stage
// ----------------------------------------------------------------------------
module rme_cordic
  import rme_pkg::*;
#(
  parameter int unsigned Steps = CordicStepsDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SyW-1:0]   y_i,
  input  logic signed [SyW-1:0]   x_i,
  output logic [AngW-1:0]         ang_o
);

  localparam int unsigned N = (Steps > TabLen) ? TabLen : Steps;

  cd_t st_q [N+1];
  cd_t pre_d;
  logic [AngW-1:0] ang_q;

  always_comb begin
    logic signed [CdW-1:0] xs, ys;
    xs = CdW'(x_i) <<< 16;
    ys = CdW'(y_i) <<< 16;
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x = xs;
    pre_d.y = ys;
    pre_d.acc = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        pre_d.x = ys; pre_d.y = -xs; pre_d.acc = PiHalf;
      end else begin
        pre_d.x = -ys; pre_d.y = xs; pre_d.acc = -PiHalf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= pre_d;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    cd_t nx;
    always_comb begin
      nx = st_q[g];
      if (!st_q[g].y[CdW-1]) begin
        nx.x   = st_q[g].x + (st_q[g].y >>> g);
        nx.y   = st_q[g].y - (st_q[g].x >>> g);
        nx.acc = st_q[g].acc + atan_tab(5'(g));
      end else begin
        nx.x   = st_q[g].x - (st_q[g].y >>> g);
        nx.y   = st_q[g].y + (st_q[g].x >>> g);
        nx.acc = st_q[g].acc - atan_tab(5'(g));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[g+1] <= nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ang_q <= st_q[N].zero ? '0 : acc_to_angle(st_q[N].acc);
  end

  assign ang_o = ang_q;

endmodule

[rtl/rotation_matrix_to_euler.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler: Z-Y-X Euler angles from a rotation matrix
// One matrix per cycle unless the output stalls; the pipeline holds four
// registers of square and bit-pair square root for sy, one register for the
// limit compare, then a CORDIC pipeline with a pre-rotation register, one
// stage per rotation step and a rounding register.
// Stalls freeze the whole pipeline; a transfer out frees a slot in the same
// cycle. tdata in: r00,r10,r20,r21,r22,r12,r11 (16 bits each, Q2.14);
// tdata out: angle_x, angle_y, angle_z (Q3.13 radians); tuser out: singular
// flag, with angle_z forced to zero when it is set.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler
  import rme_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [14:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // r00, r10, r20, r21, r22, r12, r11
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,   // angle_x, angle_y, angle_z
  output logic          m_axis_tuser    // singular
);

  localparam int unsigned Pre  = 5;
  localparam int unsigned N    = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int unsigned Lat  = Pre + N + 2;

  logic [LimitW-1:0] lim_q;
  logic en;
  logic [Lat-1:0] vld_q;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimitW'(1);
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) lim_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // stage 1: squares
  logic signed [ElemW-1:0] r00_w, r10_w;
  logic signed [SqW-1:0] p00_w, p10_w;
  logic signed [ElemW-1:0] d_q [4][7];
  logic [SqW-1:0] sq_q;
  assign r00_w = s_axis_tdata[15:0];
  assign r10_w = s_axis_tdata[31:16];
  assign p00_w = r00_w * r00_w;
  assign p10_w = r10_w * r10_w;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 7; k++) d_q[0][k] <= s_axis_tdata[16*k +: 16];
      sq_q <= $unsigned(p00_w) + $unsigned(p10_w);
    end
  end

  // stages 2..4: exact bit-pair root, six, five and five pairs per stage
  logic [SqW-1:0] rv_q [4];
  logic [SyW-1:0] rr_q [4];
  assign rv_q[0] = sq_q;
  assign rr_q[0] = '0;
  for (genvar s = 0; s < 3; s++) begin : g_rt
    localparam int unsigned P0 = (s == 0) ? 0 : (s == 1) ? 6 : 11;
    localparam int unsigned NP = (s == 0) ? 6 : 5;
    logic [SqW-1:0] rv;
    logic [SyW-1:0] rr;
    always_comb begin
      logic [SqW+1:0] trial;
      rv = rv_q[s];
      rr = rr_q[s];
      for (int b = 0; b < NP; b++) begin
        trial = ({2'b0, 32'(rr)} << 2) | 34'd1;
        trial = trial << (2 * (15 - (P0 + b)));
        if ({2'b0, rv} >= trial) begin
          rv = rv - trial[SqW-1:0];
          rr = (rr << 1) | SyW'(1);
        end else begin
          rr = rr << 1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rv_q[s+1] <= rv;
        rr_q[s+1] <= rr;
        d_q[s+1] <= d_q[s];
      end
    end
  end

  // stage 5: compare and operand select
  logic sg_q;
  logic signed [SyW-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sg_q <= rr_q[3] < SyW'(lim_q);
      ya_q <= -SyW'(d_q[3][2]);
      yb_q <= $signed(rr_q[3]);
      if (rr_q[3] < SyW'(lim_q)) begin
        xa_q <= -SyW'(d_q[3][5]);
        xb_q <= SyW'(d_q[3][6]);
      end else begin
        xa_q <= SyW'(d_q[3][3]);
        xb_q <= SyW'(d_q[3][4]);
      end
      za_q <= SyW'(d_q[3][1]);
      zb_q <= SyW'(d_q[3][0]);
    end
  end

  logic [AngW-1:0] ax, ay, az;
  rme_cordic #(.Steps(CORDIC_STEPS)) u_x (.clk_i, .en_i(en), .y_i(xa_q), .x_i(xb_q), .ang_o(ax));
  rme_cordic #(.Steps(CORDIC_STEPS)) u_y (.clk_i, .en_i(en), .y_i(ya_q), .x_i(yb_q), .ang_o(ay));
  rme_cordic #(.Steps(CORDIC_STEPS)) u_z (.clk_i, .en_i(en), .y_i(za_q), .x_i(zb_q), .ang_o(az));

  logic [N+1:0] sgp_q;
  always_ff @(posedge clk_i) begin
    if (en) sgp_q <= {sgp_q[N:0], sg_q};
  end

  assign m_axis_tdata = {sgp_q[N+1] ? 16'h0 : az, ay, ax};
  assign m_axis_tuser = sgp_q[N+1];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_zsing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:32] == 16'h0)
    else $error("angle_z nonzero when singular");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

[verif/rotation_matrix_to_euler_test.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_test: self-checking bench for the euler converter
// drives matrices over the input stream with random gaps and output stalls,
// predicts each angle triple and singular flag with a CORDIC model of its own
// and compares every output transfer; the singularity limit is swept
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_test
  import rme_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps    = (CordicStepsDef > TabLen) ? TabLen : CordicStepsDef;
  localparam int Latency  = 5 + Steps + 2;
  localparam int IdleLimit = 4000;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic        singular;
  } euler_t;

  typedef logic [15:0] matrix_t [7];

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [14:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata = '0;  // r00, r10, r20, r21, r22, r12, r11
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [47:0]   m_axis_tdata;       // angle_x, angle_y, angle_z
  logic          m_axis_tuser;       // singular

  euler_t  angles_pending[$];
  longint  atan_q29[TabLen];
  logic [14:0] limit_q = 15'd1;
  bit      gaps_on = 1'b1;
  int      errors = 0;
  int      n_sent = 0;
  int      n_seen = 0;
  int      n_sing = 0;
  int      idle_cycles = 0;
  int      out_stall = 0;

  rotation_matrix_to_euler u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  function automatic void build_atan_table();
    longint sum, term;
    int p;
    atan_q29[0] = 64'sd421657428;
    for (int i = 1; i < TabLen; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        p = i * (2 * k + 1);
        if (p > 62) break;
        term = (64'sd1 <<< (62 - p)) / (2 * k + 1);
        sum += (k % 2) ? -term : term;
      end
      atan_q29[i] = (sum + (64'sd1 <<< 32)) >>> 33;
    end
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bits;
    res = 0;
    bits = 64'sd1 <<< 62;
    while (bits > v) bits = bits >>> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >>> 1) + bits;
      end else begin
        res = res >>> 1;
      end
      bits = bits >>> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] atan2_q13(longint y, longint x);
    longint acc, t, dx, dy, r;
    acc = 0;
    if (x == 0 && y == 0) return 16'd0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; acc = 64'sd843314857;
      end else begin
        t = -y; y = x; x = t; acc = -64'sd843314857;
      end
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += atan_q29[i];
      end else begin
        x -= dx; y += dy; acc -= atan_q29[i];
      end
    end
    r = (acc + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic euler_t predict_euler(matrix_t m, logic [14:0] lim);
    euler_t e;
    longint r00, r10, sy;
    r00 = longint'(signed'(m[0]));
    r10 = longint'(signed'(m[1]));
    sy = int_sqrt(r00 * r00 + r10 * r10);
    e.singular = (sy < longint'(lim));
    e.angle_y = atan2_q13(-longint'(signed'(m[2])), sy);
    if (!e.singular) begin
      e.angle_x = atan2_q13(longint'(signed'(m[3])), longint'(signed'(m[4])));
      e.angle_z = atan2_q13(r10, r00);
    end else begin
      e.angle_x = atan2_q13(-longint'(signed'(m[5])), longint'(signed'(m[6])));
      e.angle_z = 16'd0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h expected %h", n_seen, what, got, want);
  endtask

  // output side: random stalls and checking
  always @(posedge clk_i) begin
    euler_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.angle_x = m_axis_tdata[15:0];
      got.angle_y = m_axis_tdata[31:16];
      got.angle_z = m_axis_tdata[47:32];
      got.singular = m_axis_tuser;
      if (angles_pending.size() == 0) begin
        errors++;
        $display("unexpected output transfer %0d: %h", n_seen, m_axis_tdata);
      end else begin
        want = angles_pending.pop_front();
        if (got.angle_x !== want.angle_x) report_mismatch("angle_x", got.angle_x, want.angle_x);
        if (got.angle_y !== want.angle_y) report_mismatch("angle_y", got.angle_y, want.angle_y);
        if (got.angle_z !== want.angle_z) report_mismatch("angle_z", got.angle_z, want.angle_z);
        if (got.singular !== want.singular)
          report_mismatch("singular", 16'(got.singular), 16'(want.singular));
        if (want.singular) n_sing++;
      end
      n_seen++;
      out_stall = gaps_on ? $urandom_range(0, 3) : 0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("rotation_matrix_to_euler_test: FAIL");
        $finish;
      end
    end
  end

  task automatic send_matrix(matrix_t m);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    angles_pending.push_back(predict_euler(m, limit_q));
    n_sent++;
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (angles_pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [14:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_q = v;
  endtask

  // mode 0 full range, 1 small r00 and r10, 2 magnitudes up to one
  function automatic matrix_t random_matrix(int mode);
    matrix_t m;
    for (int i = 0; i < 7; i++) begin
      case (mode)
        1: m[i] = (i < 2) ? 16'($signed($urandom_range(0, 400)) - 200) : 16'($urandom);
        2: m[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
        default: m[i] = 16'($urandom);
      endcase
    end
    if (mode == 1 && $urandom_range(0, 7) == 0) begin
      m[0] = '0;
      m[1] = '0;
    end
    return m;
  endfunction

  task automatic run_random(int count, int mode_max);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_matrix(random_matrix($urandom_range(0, mode_max)));
    end
    stop_input();
    gaps_on = 1'b1;
  endtask

  task automatic test_directed();
    matrix_t m;
    m = '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000};
    send_matrix(m);
    m = '{default: 16'h0000};
    send_matrix(m);
    m = '{default: 16'h7fff};
    send_matrix(m);
    m = '{default: 16'h8000};
    send_matrix(m);
    m = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
    send_matrix(m);
    m = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    send_matrix(m);
    // gimbal lock: r00 and r10 zero, both branches of the quadrant turn
    m = '{16'h0000, 16'h0000, 16'hc000, 16'h1234, 16'hc000, 16'h2000, 16'hc000};
    send_matrix(m);
    m = '{16'h0000, 16'h0000, 16'h4000, 16'h1234, 16'hc000, 16'he000, 16'hc000};
    send_matrix(m);
    // negative x with positive and negative y
    m = '{16'hc000, 16'h0100, 16'h0001, 16'h0100, 16'hc000, 16'h0000, 16'h0001};
    send_matrix(m);
    m = '{16'hc000, 16'hff00, 16'hffff, 16'hff00, 16'hc000, 16'h0001, 16'h0000};
    send_matrix(m);
    m = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0001};
    send_matrix(m);
    m = '{16'h0000, 16'hffff, 16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h0000};
    send_matrix(m);
    stop_input();
  endtask

  task automatic test_random_reset_limit();
    run_random(250, 2);
  endtask

  task automatic test_limit_extremes();
    matrix_t m;
    write_limit(15'd0);
    m = '{default: 16'h0000};
    send_matrix(m);
    run_random(200, 2);
    write_limit(15'h7fff);
    m = '{16'h7fff, 16'h7fff, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
    send_matrix(m);
    m = '{16'h8000, 16'h8000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
    send_matrix(m);
    run_random(200, 2);
  endtask

  task automatic test_limit_sweep();
    write_limit(15'd100);
    run_random(250, 1);
    write_limit(15'd16384);
    run_random(250, 2);
    write_limit(15'($urandom));
    run_random(200, 2);
    write_limit(15'd1);
    run_random(100, 1);
  endtask

  initial begin
    build_atan_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random_reset_limit();
    test_limit_extremes();
    test_limit_sweep();
    wait_drained();
    $display("sent %0d matrices, checked %0d results, %0d of them singular",
             n_sent, n_seen, n_sing);
    $display("limit settings covered: reset, zero, full scale and mid values");
    if (errors == 0 && angles_pending.size() == 0) begin
      $display("rotation_matrix_to_euler_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, angles_pending.size());
      $display("rotation_matrix_to_euler_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rme_pkg.sv
rtl/rme_cordic.sv
rtl/rotation_matrix_to_euler.sv
verif/rotation_matrix_to_euler_test.sv
